### sv/nmea_rmc_gga_field_extractor_top_assert.svh
// Assertion macros for the NMEA field extractor.
// Needs i_clk and i_rst_n in the scope that uses them; SYNTH selects empty bodies.
`ifndef NMEA_RMC_GGA_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_RMC_GGA_FIELD_EXTRACTOR_TOP_ASSERT_SVH

`ifndef SYNTH

// Check a same-cycle implication
`define NFX_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nmea_fx: same-cycle check failed");

// Check an implication one cycle on
`define NFX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nmea_fx: next-cycle check failed");

`else

`define NFX_ASSERT_IMPLY(lbl, ante, cons)
`define NFX_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/nmea_fx_pkg.sv
// Types and constants for the NMEA RMC/GGA field extractor.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package nmea_fx_pkg;

    // Sentence kind of the current sentence
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_RMC   = 2'd1,
        KIND_GGA   = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // Field store rows
    typedef logic [2:0] t_field;
    localparam t_field FLD_TIME   = 3'd0;
    localparam t_field FLD_DATE   = 3'd1;
    localparam t_field FLD_LAT    = 3'd2;
    localparam t_field FLD_LON    = 3'd3;
    localparam t_field FLD_SPEED  = 3'd4;
    localparam t_field FLD_COURSE = 3'd5;
    localparam t_field FLD_SATS   = 3'd6;
    localparam t_field FLD_ALT    = 3'd7;
    localparam int     FIELD_COUNT = 8;

    // Channel commands
    localparam logic CMD_FEED = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Term numbers
    typedef logic [3:0] t_term_num;
    localparam t_term_num TERM_MAX_NUMBER = 4'd15;
    localparam t_term_num TN_RMC_TIME     = 4'd1;
    localparam t_term_num TN_RMC_LAT      = 4'd3;
    localparam t_term_num TN_RMC_LAT_HEM  = 4'd4;
    localparam t_term_num TN_RMC_LON      = 4'd5;
    localparam t_term_num TN_RMC_LON_HEM  = 4'd6;
    localparam t_term_num TN_RMC_SPEED    = 4'd7;
    localparam t_term_num TN_RMC_COURSE   = 4'd8;
    localparam t_term_num TN_RMC_DATE     = 4'd9;
    localparam t_term_num TN_GGA_SATS     = 4'd7;
    localparam t_term_num TN_GGA_ALT      = 4'd9;

    // Characters
    typedef logic [7:0] t_byte;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_NORTH  = 8'h4E;
    localparam t_byte CH_EAST   = 8'h45;
    localparam t_byte CH_MINUS  = 8'h2D;
    localparam t_byte CH_ZERO   = 8'h30;

    // Sentence tags, first character in the top byte
    localparam logic [39:0] TAG_RMC = "GPRMC";
    localparam logic [39:0] TAG_GGA = "GPGGA";
    localparam int          TAG_LEN = 5;

endpackage

`default_nettype wire

### sv/nmea_fx_if.sv
// Valid/ready channel interfaces for the NMEA field extractor.
// Input carries one command item, output one result item; uses nmea_fx_pkg.
`default_nettype none

interface nmea_fx_in_if;
    import nmea_fx_pkg::*;

    logic   valid;
    logic   ready;
    logic   command;
    t_byte  rx_byte;
    t_field field_select;
    logic [3:0] char_index;

    modport source (output valid, command, rx_byte, field_select, char_index, input ready);
    modport sink   (input valid, command, rx_byte, field_select, char_index, output ready);
endinterface

interface nmea_fx_out_if;
    import nmea_fx_pkg::*;

    logic  valid;
    logic  ready;
    logic  fix_ready;
    t_byte read_char;

    modport source (output valid, fix_ready, read_char, input ready);
    modport sink   (input valid, fix_ready, read_char, output ready);
endinterface

`default_nettype wire

### sv/nmea_rmc_gga_field_extractor_top.sv
// NMEA RMC/GGA field extractor: term splitter, field store and read path.
// Depends on nmea_fx_pkg, nmea_fx_if.sv and the assertion macro header.
//
// Usage:
//  i_in carries one item per handshake: command 0 feeds rx_byte into the
//  sentence parser, command 1 reads character char_index of field
//  field_select. o_res returns exactly one item per input item, in order:
//  fix_ready pulses on the carriage return that completes both an RMC and
//  a GGA sentence; read_char holds the stored character (0 past the text
//  and for feed items).
//  The result item passes through the stage 1 register and then the output
//  register before o_res presents it; a stall at o_res holds it there.
//  Throughput: one item per cycle while o_res does not stall, set by the
//  term update and the one-row-per-cycle field memory port.
//  Reset (synchronous, active low) clears the term count, sentence kind,
//  seen flags, pipeline valids and the eight row valid bits of the field
//  memory; a row that was never written reads as zero, so no clearing pass
//  is needed and items are taken from the first cycle after reset.
//  When the receiver stalls, the output register and the middle stage hold
//  their items and i_in.ready drops once both are full.
`default_nettype none

`include "nmea_rmc_gga_field_extractor_top_assert.svh"

module nmea_rmc_gga_field_extractor_top #(
    parameter int TERM_BYTES  = 12,
    parameter int FIELD_BYTES = 13
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    nmea_fx_in_if.sink     i_in,
    nmea_fx_out_if.source  o_res
);
    import nmea_fx_pkg::*;

    localparam int LW  = $clog2(TERM_BYTES + 1);
    localparam int TIW = $clog2(TERM_BYTES);
    localparam int IW  = $clog2(FIELD_BYTES);

    typedef logic [FIELD_BYTES-1:0][7:0] t_row;

    // Parser state
    t_byte              r_term_text [TERM_BYTES];
    logic [LW-1:0]      r_term_len, n_term_len;
    t_term_num          r_term_number, n_term_number;
    t_kind              r_kind, n_kind;
    logic               r_rmc_seen, n_rmc_seen;
    logic               r_gga_seen, n_gga_seen;
    logic               n_fix;
    logic               w_append;

    // Field memory, one row per field, byte enables
    t_row                   r_mem [FIELD_COUNT];
    logic [FIELD_COUNT-1:0] r_row_valid;
    logic                   w_we;
    t_field                 w_waddr;
    logic [FIELD_BYTES-1:0] w_wbe;
    t_row                   w_wdata;

    // Pipeline
    logic        r_s1_valid, r_s1_cmd, r_s1_fix, r_s1_rowv;
    logic [3:0]  r_s1_idx;
    t_row        r_s1_row;
    logic        r_out_valid, r_out_fix;
    t_byte       r_out_char;
    logic        w_out_en, w_s1_en, w_accept;
    t_byte       w_char;
    logic [IW-1:0] w_idx;

    // Copy and route helpers
    t_byte       w_src   [FIELD_BYTES];
    t_row        w_copy0, w_copy1;
    logic        w_is_rmc, w_is_gga;
    t_kind       w_kind_eff;
    logic        w_do_copy, w_do_sign, w_start1;
    t_field      w_field;
    t_byte       w_mark;
    logic        w_positive;

    // Handshake: each stage advances when the one after it frees up
    assign w_out_en  = !r_out_valid || o_res.ready;
    assign w_s1_en   = !r_s1_valid || w_out_en;
    assign w_accept  = i_in.valid && w_s1_en;
    assign i_in.ready = w_s1_en;

    assign o_res.valid     = r_out_valid;
    assign o_res.fix_ready = r_out_fix;
    assign o_res.read_char = r_out_char;

    // Match term 0 against both tags
    always_comb begin
        w_is_rmc = (32'(r_term_len) == TAG_LEN);
        w_is_gga = (32'(r_term_len) == TAG_LEN);
        for (int i = 0; i < TAG_LEN; i++) begin
            if (r_term_text[i] != TAG_RMC[(TAG_LEN-1-i)*8 +: 8]) w_is_rmc = 1'b0;
            if (r_term_text[i] != TAG_GGA[(TAG_LEN-1-i)*8 +: 8]) w_is_gga = 1'b0;
        end
    end

    // Build the term as it lands from slot 0 and from slot 1, zero-filled
    always_comb begin
        for (int s = 0; s < FIELD_BYTES; s++) begin
            if (s < TERM_BYTES && s < 32'(r_term_len)) begin
                w_src[s] = r_term_text[(s < TERM_BYTES) ? s : 0];
            end else begin
                w_src[s] = '0;
            end
            w_copy0[s] = w_src[s];
        end
        w_copy1[0] = '0;
        for (int s = 1; s < FIELD_BYTES; s++) begin
            w_copy1[s] = w_src[s-1];
        end
    end

    // Pick the kind in force and the store that this term goes to
    always_comb begin
        if (r_term_number == '0) begin
            if (w_is_rmc) begin
                w_kind_eff = KIND_RMC;
            end else if (w_is_gga) begin
                w_kind_eff = KIND_GGA;
            end else begin
                w_kind_eff = KIND_OTHER;
            end
        end else begin
            w_kind_eff = r_kind;
        end

        w_do_copy = 1'b0;
        w_do_sign = 1'b0;
        w_start1  = 1'b0;
        w_field   = FLD_TIME;
        w_mark    = CH_NORTH;
        unique case (w_kind_eff)
            KIND_RMC: begin
                unique case (r_term_number)
                    TN_RMC_TIME:    begin w_do_copy = 1'b1; w_field = FLD_TIME; end
                    TN_RMC_LAT:     begin
                        w_do_copy = 1'b1; w_field = FLD_LAT; w_start1 = 1'b1;
                    end
                    TN_RMC_LAT_HEM: begin
                        w_do_sign = 1'b1; w_field = FLD_LAT; w_mark = CH_NORTH;
                    end
                    TN_RMC_LON:     begin
                        w_do_copy = 1'b1; w_field = FLD_LON; w_start1 = 1'b1;
                    end
                    TN_RMC_LON_HEM: begin
                        w_do_sign = 1'b1; w_field = FLD_LON; w_mark = CH_EAST;
                    end
                    TN_RMC_SPEED:   begin w_do_copy = 1'b1; w_field = FLD_SPEED; end
                    TN_RMC_COURSE:  begin w_do_copy = 1'b1; w_field = FLD_COURSE; end
                    TN_RMC_DATE:    begin w_do_copy = 1'b1; w_field = FLD_DATE; end
                    default: ;
                endcase
            end
            KIND_GGA: begin
                unique case (r_term_number)
                    TN_GGA_SATS: begin w_do_copy = 1'b1; w_field = FLD_SATS; end
                    TN_GGA_ALT:  begin w_do_copy = 1'b1; w_field = FLD_ALT; end
                    default: ;
                endcase
            end
            default: ;
        endcase
        w_positive = (r_term_len != '0) && (r_term_text[0] == w_mark);
    end

    // Next parser state and the memory write for one feed item
    always_comb begin
        n_term_len    = r_term_len;
        n_term_number = r_term_number;
        n_kind        = r_kind;
        n_rmc_seen    = r_rmc_seen;
        n_gga_seen    = r_gga_seen;
        n_fix         = 1'b0;
        w_append      = 1'b0;
        w_we          = 1'b0;
        w_waddr       = w_field;
        w_wbe         = '0;
        w_wdata       = '0;

        if (i_in.command == CMD_FEED) begin
            priority if (i_in.rx_byte == CH_CR) begin
                if (r_kind == KIND_RMC) n_rmc_seen = 1'b1;
                if (r_kind == KIND_GGA) n_gga_seen = 1'b1;
                if (n_rmc_seen && n_gga_seen) begin
                    n_rmc_seen = 1'b0;
                    n_gga_seen = 1'b0;
                    n_fix      = 1'b1;
                end
            end else if (i_in.rx_byte == CH_DOLLAR) begin
                n_term_number = '0;
                n_term_len    = '0;
            end else if (i_in.rx_byte == CH_COMMA) begin
                n_kind = w_kind_eff;
                if (w_do_copy) begin
                    w_we    = 1'b1;
                    w_wdata = w_start1 ? w_copy1 : w_copy0;
                    w_wbe   = w_start1 ? {{(FIELD_BYTES-1){1'b1}}, 1'b0} : '1;
                end else if (w_do_sign) begin
                    w_we       = 1'b1;
                    w_wdata[0] = w_positive ? CH_ZERO : CH_MINUS;
                    w_wbe[0]   = 1'b1;
                end
                if (r_term_number != TERM_MAX_NUMBER) begin
                    n_term_number = r_term_number + 4'd1;
                end
                n_term_len = '0;
            end else begin
                // Append below the term limit, drop anything past it
                if (32'(r_term_len) < TERM_BYTES) begin
                    w_append   = 1'b1;
                    n_term_len = r_term_len + LW'(1);
                end
            end
        end

        // First write to a row fills all of it, zeros outside the term
        if (!r_row_valid[w_waddr]) begin
            w_wbe = '1;
        end
    end

    // Hold parser control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_len    <= '0;
            r_term_number <= '0;
            r_kind        <= KIND_NONE;
            r_rmc_seen    <= 1'b0;
            r_gga_seen    <= 1'b0;
        end else if (w_accept) begin
            r_term_len    <= n_term_len;
            r_term_number <= n_term_number;
            r_kind        <= n_kind;
            r_rmc_seen    <= n_rmc_seen;
            r_gga_seen    <= n_gga_seen;
        end
    end

    // Append a character to the term
    always_ff @(posedge i_clk) begin
        if (w_accept && w_append) begin
            r_term_text[r_term_len[TIW-1:0]] <= i_in.rx_byte;
        end
    end

    // Write the field memory and mark rows valid
    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            for (int b = 0; b < FIELD_BYTES; b++) begin
                if (w_wbe[b]) r_mem[w_waddr][b] <= w_wdata[b];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (w_accept && w_we) begin
            r_row_valid[w_waddr] <= 1'b1;
        end
    end

    // Stage 1: registered row read and item control
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_row  <= r_mem[i_in.field_select];
            r_s1_rowv <= r_row_valid[i_in.field_select];
            r_s1_cmd  <= i_in.command;
            r_s1_idx  <= i_in.char_index;
            r_s1_fix  <= n_fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_en) begin
            r_s1_valid <= i_in.valid;
        end
    end

    // Select the character, zero past the field or for a feed item
    assign w_idx = IW'(r_s1_idx);
    always_comb begin
        w_char = '0;
        if (r_s1_cmd == CMD_READ && r_s1_rowv && 32'(r_s1_idx) < FIELD_BYTES) begin
            w_char = r_s1_row[w_idx];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_out_fix  <= r_s1_fix;
            r_out_char <= w_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // Checks on the parser and pipeline
    `NFX_ASSERT_IMPLY(a_term_len_bound, 1'b1, 32'(r_term_len) <= TERM_BYTES)
    `NFX_ASSERT_NEXT(a_fix_clears_seen, w_accept && n_fix, !r_rmc_seen && !r_gga_seen)
    `NFX_ASSERT_NEXT(a_read_keeps_terms, w_accept && i_in.command == CMD_READ,
        $stable(r_term_len) && $stable(r_term_number) && $stable(r_kind))
    `NFX_ASSERT_IMPLY(a_fix_only_feed, r_out_valid && r_out_fix, r_out_char == '0)
    `NFX_ASSERT_NEXT(a_s1_held, r_s1_valid && !w_out_en, r_s1_valid && $stable(r_s1_idx))

endmodule

`default_nettype wire
